FILE: rtl/core/set_assoc_cache_hit_miss_model_macros.svh
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_CACHE_HIT_MISS_MODEL_MACROS_SVH
`define SET_ASSOC_CACHE_HIT_MISS_MODEL_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SACHM_AST(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cache model check failed");
// Check a property on every clock edge, reset included.
`define SACHM_AST_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("cache model check failed");
`else
`define SACHM_AST(lbl, prop)
`define SACHM_AST_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/sachm_pkg.sv
// Shared types and constants for the set-associative cache model.
`timescale 1ns / 1ps
package sachm_pkg;

  localparam int NUM_SETS    = 64;
  localparam int SET_W       = 6;
  localparam int NUM_WAYS    = 8;
  localparam int WAY_W       = 3;
  localparam int WCNT_W      = 4;
  localparam int ADDR_W      = 48;
  localparam int TAG_W       = 48;
  localparam int STAMP_W     = 64;
  localparam int CNT_W       = 32;
  localparam int OUT_DATA_W  = 136;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LRU_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd3;

  // One set as stored in the line memory
  typedef struct packed {
    logic [NUM_WAYS-1:0]               valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0]    tag;
    logic [NUM_WAYS-1:0][STAMP_W-1:0]  stamp;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
    logic use_victim;
    logic evict_start;
    logic evict_step;
    logic clr_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic fast_ok;
    logic evict_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/set_assoc_cache_hit_miss_model.sv
// Top level of the set-associative cache hit/miss model.
// Usage:
//   in_*  : one memory access per item; in_tdata holds the 48-bit byte address,
//           in_tuser holds the access kind (0 read, 1 write).
//   out_* : one result per access; hit, fill flag and four saturating totals
//           that include the current access.
//   cfg_* : register writes (0 policy, 1 offset bits, 2 index bits, 3 ways),
//           always ready; write only while no access is in flight.
// Flow: the accept cycle reads the set row from the line memory; the next
//   cycle compares the used ways and, once the output register is free,
//   commits an item that hits or finds a free way (the row is written back on
//   a miss or under LRU). A miss into a full set walks the used ways for the
//   oldest stamp, one way per cycle; the line memory's read-modify-write sets the rate.
// Reset: a clearing pass zeroes all 64 set rows; no item is taken
//   until it ends. Counters, clock and registers return to their defaults.
// Stall: a result waits in the output register; the next item is accepted and
//   looked up meanwhile, but its commit holds until the register is taken.
`timescale 1ns / 1ps
module set_assoc_cache_hit_miss_model
  import sachm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // address at [47:0]
  input  logic [ADDR_W-1:0]     in_tdata,
  // mode at [0]
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // hit [0], fill_read [1], total_reads [33:2], total_writes [65:34],
  // total_hits [97:66], total_misses [129:98], zero [135:130]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sachm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sachm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_address (in_tdata),
    .in_mode    (in_tuser),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

FILE: rtl/core/sachm_ctrl.sv
// Controller state machine for the set-associative cache model.
`timescale 1ns / 1ps
`include "set_assoc_cache_hit_miss_model_macros.svh"
module sachm_ctrl
  import sachm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_EVICT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequence clear, lookup, victim walk and commit
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.fast_ok) begin
          if (sts.out_free) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          cmd.evict_start = 1'b1;
          state_nxt       = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!sts.evict_done) begin
          cmd.evict_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.commit     = 1'b1;
          cmd.use_victim = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SACHM_AST(ast_commit_needs_slot, cmd.commit |-> sts.out_free)
  `SACHM_AST(ast_evict_only_on_full_miss, cmd.evict_start |-> !sts.fast_ok)
  `SACHM_AST(ast_look_follows_load, cmd.load |=> (state_r == S_LOOK))

endmodule

FILE: rtl/core/sachm_dp.sv
// Datapath: line memory, tag compare, victim walk, counters and output register.
`timescale 1ns / 1ps
`include "set_assoc_cache_hit_miss_model_macros.svh"
module sachm_dp
  import sachm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  in_mode,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  // Configuration registers
  logic       lru_r;
  logic [4:0] offset_r;
  logic [2:0] index_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lru_r    <= 1'b0;
      offset_r <= 5'd4;
      index_r  <= 3'd6;
      ways_r   <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LRU_POLICY:  lru_r    <= cfg_wdata[0];
        CFG_OFFSET_BITS: offset_r <= cfg_wdata;
        CFG_INDEX_BITS:  index_r  <= cfg_wdata[2:0];
        CFG_WAYS_USED:   ways_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the way count to one through NUM_WAYS
  logic [WCNT_W-1:0] eff_ways;
  always_comb begin
    if (ways_r == '0) begin
      eff_ways = WCNT_W'(1);
    end else if (ways_r > WCNT_W'(NUM_WAYS)) begin
      eff_ways = WCNT_W'(NUM_WAYS);
    end else begin
      eff_ways = ways_r;
    end
  end

  // Split the incoming address into set and tag
  logic [ADDR_W-1:0] off_shifted;
  logic [ADDR_W-1:0] tag_shifted;
  logic [5:0]        tag_shift;
  logic [6:0]        set_field;
  logic [SET_W-1:0]  in_set;

  assign off_shifted = in_address >> offset_r;
  assign tag_shift   = {1'b0, offset_r} + {3'b000, index_r};
  assign tag_shifted = in_address >> tag_shift;
  assign set_field   = off_shifted[6:0] & ((7'd1 << index_r) - 7'd1);
  assign in_set      = set_field[SET_W-1:0];

  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             mode_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_r  <= in_set;
      tag_r  <= TAG_W'(tag_shifted);
      mode_r <= in_mode;
    end
  end

  // Line memory: one row per set, read on accept, written on clear or row update
  row_t             mem [NUM_SETS];
  row_t             row_r;
  row_t             new_row;
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  row_t             mem_wd;
  logic             row_upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.load) begin
      row_r <= mem[in_set];
    end
  end

  // Clearing pass counter
  logic [SET_W-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + SET_W'(1);
    end
  end

  // Search used ways for a hit and for the first free way
  logic             hit_any;
  logic             free_any;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WCNT_W'(w) < eff_ways) begin
        if (!hit_any && row_r.valid[w] && row_r.tag[w] == tag_r) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(w);
        end
        if (!free_any && !row_r.valid[w]) begin
          free_any = 1'b1;
          free_way = WAY_W'(w);
        end
      end
    end
  end

  // Walk the used ways for the oldest stamp, later ways winning ties
  logic [WAY_W-1:0]  victim_r;
  logic [WCNT_W-1:0] walk_r;

  always_ff @(posedge clk) begin
    if (cmd.evict_start) begin
      victim_r <= '0;
      walk_r   <= WCNT_W'(1);
    end else if (cmd.evict_step) begin
      if (row_r.stamp[walk_r[WAY_W-1:0]] <= row_r.stamp[victim_r]) begin
        victim_r <= walk_r[WAY_W-1:0];
      end
      walk_r <= walk_r + WCNT_W'(1);
    end
  end

  // Commit: pick the way, update totals; row and clock only on a miss or LRU
  logic               c_hit;
  logic [WAY_W-1:0]   c_way;
  logic [STAMP_W-1:0] clock_r;
  logic [STAMP_W-1:0] clock_inc;
  logic [CNT_W-1:0]   reads_r, writes_r, hits_r, misses_r;
  logic [CNT_W-1:0]   reads_nxt, writes_nxt, hits_nxt, misses_nxt;

  assign c_hit     = !cmd.use_victim && hit_any;
  assign c_way     = cmd.use_victim ? victim_r : (hit_any ? hit_way : free_way);
  assign clock_inc = clock_r + STAMP_W'(1);
  assign row_upd   = !c_hit || lru_r;

  always_comb begin
    new_row              = row_r;
    new_row.stamp[c_way] = clock_inc;
    if (!c_hit) begin
      new_row.valid[c_way] = 1'b1;
      new_row.tag[c_way]   = tag_r;
    end
  end

  assign mem_we = cmd.clr_step || (cmd.commit && row_upd);
  assign mem_wa = cmd.clr_step ? clr_cnt_r : set_r;
  assign mem_wd = cmd.clr_step ? row_t'('0) : new_row;

  always_comb begin
    reads_nxt  = reads_r;
    writes_nxt = writes_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (mode_r && writes_r != '1) begin
      writes_nxt = writes_r + CNT_W'(1);
    end
    if (c_hit) begin
      if (hits_r != '1) begin
        hits_nxt = hits_r + CNT_W'(1);
      end
    end else begin
      if (misses_r != '1) begin
        misses_nxt = misses_r + CNT_W'(1);
      end
      if (reads_r != '1) begin
        reads_nxt = reads_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= '0;
      reads_r  <= '0;
      writes_r <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.commit) begin
      if (row_upd) begin
        clock_r <= clock_inc;
      end
      reads_r  <= reads_nxt;
      writes_r <= writes_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  // Output register: load on commit, drop when taken
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {6'd0, misses_nxt, hits_nxt, writes_nxt, reads_nxt, !c_hit, c_hit};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_last   = (clr_cnt_r == '1);
  assign sts.fast_ok    = hit_any || free_any;
  assign sts.evict_done = (walk_r >= eff_ways);
  assign sts.out_free   = !out_valid_r || out_ready;

  `SACHM_AST(ast_commit_loads_out, cmd.commit |=> out_valid_r)
  `SACHM_AST(ast_miss_advances_clock,
             (cmd.commit && !c_hit) |=> (clock_r == STAMP_W'($past(clock_r) + STAMP_W'(1))))
  `SACHM_AST(ast_victim_in_range, cmd.use_victim |-> (WCNT_W'(victim_r) < eff_ways))

endmodule

FILE: tb/tb_set_assoc_cache_hit_miss_model.sv
// Self-checking testbench for the set-associative cache hit/miss model.
`timescale 1ns / 1ps
module tb_set_assoc_cache_hit_miss_model;
  import sachm_pkg::*;

  localparam int LINES       = NUM_SETS * NUM_WAYS;
  localparam int PHASE_ITEMS = 230;
  localparam int LONG_HOLD   = 400;
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    FLOW_FULL,
    FLOW_SRC_GAPS,
    FLOW_SINK_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef enum logic {
    ROW_ACCESS,
    ROW_REG_WRITE
  } row_kind_e;

  typedef struct {
    logic        hit;
    logic        fill;
    logic [31:0] reads;
    logic [31:0] writes;
    logic [31:0] hits;
    logic [31:0] misses;
  } access_result_t;

  typedef struct {
    row_kind_e            kind;
    logic [ADDR_W-1:0]    addr;
    logic                 mode;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                   known;
    access_result_t       res;
  } stim_row_t;

  typedef struct {
    logic                  lru;
    logic [CFG_DATA_W-1:0] off;
    logic [CFG_DATA_W-1:0] idx;
    logic [CFG_DATA_W-1:0] ways;
    flow_e                 flow;
  } phase_t;

  logic                  clk;
  logic                  rst_n;
  logic [ADDR_W-1:0]     in_tdata;
  logic                  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  set_assoc_cache_hit_miss_model dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow copy of the cache and its registers
  bit                 shadow_valid [LINES];
  logic [TAG_W-1:0]   shadow_tag   [LINES];
  logic [STAMP_W-1:0] shadow_stamp [LINES];
  logic [STAMP_W-1:0] shadow_clock = '0;
  logic [CNT_W-1:0]   n_reads  = '0;
  logic [CNT_W-1:0]   n_writes = '0;
  logic [CNT_W-1:0]   n_hits   = '0;
  logic [CNT_W-1:0]   n_misses = '0;
  logic               model_lru        = 1'b0;
  logic [4:0]         model_offset     = 5'd4;
  logic [2:0]         model_index_bits = 3'd6;
  logic [3:0]         model_ways       = 4'd8;

  access_result_t pending_results [$];
  int             error_count = 0;

  // Known result for the item on the bus, when the stimulus row gives one
  bit             known_valid = 1'b0;
  access_result_t known_res;

  // Traffic shaping shared by sender and receiver
  flow_e flow_mode = FLOW_FULL;
  int    hold_req  = 0;
  int    hold_left = 0;

  // Address pools of the running phase
  logic [63:0] tag_pool [12];
  logic [63:0] set_pool [4];
  int          tag_pool_n;
  int          cur_off;
  int          cur_idx;

  stim_row_t stim_table [25];
  phase_t    phases [8];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Look one access up in the shadow cache and update it
  function automatic access_result_t predict_lookup(logic [ADDR_W-1:0] addr, logic wr);
    access_result_t     r;
    int unsigned        ways;
    int unsigned        shift;
    int unsigned        base;
    int unsigned        victim;
    logic [63:0]        wide;
    logic [63:0]        set_field;
    logic [TAG_W-1:0]   tag;
    bit                 found;
    bit                 placed;
    ways = (model_ways == 0) ? 1 : ((model_ways > NUM_WAYS) ? NUM_WAYS : model_ways);
    shift = int'(model_offset) + int'(model_index_bits);
    wide = {{(64 - ADDR_W){1'b0}}, addr};
    set_field = (wide >> model_offset) & ((64'd1 << model_index_bits) - 64'd1);
    tag = (shift >= 64) ? '0 : TAG_W'(wide >> shift);
    base = int'(set_field % NUM_SETS) * NUM_WAYS;
    found = 1'b0;
    placed = 1'b0;
    if (wr) n_writes = sat_inc(n_writes);
    // search every used way before filling
    for (int w = 0; w < ways; w++) begin
      if (!found && shadow_valid[base + w] && shadow_tag[base + w] == tag) begin
        found = 1'b1;
        if (model_lru) begin
          shadow_clock = shadow_clock + 1'b1;
          shadow_stamp[base + w] = shadow_clock;
        end
      end
    end
    if (found) begin
      n_hits = sat_inc(n_hits);
    end else begin
      n_misses = sat_inc(n_misses);
      n_reads = sat_inc(n_reads);
      shadow_clock = shadow_clock + 1'b1;
      victim = base;
      for (int w = 0; w < ways; w++) begin
        if (!placed && !shadow_valid[base + w]) begin
          victim = base + w;
          placed = 1'b1;
        end
      end
      // full set: oldest stamp goes, ties to the highest way
      if (!placed) begin
        victim = base;
        for (int w = 0; w < ways; w++) begin
          if (shadow_stamp[base + w] <= shadow_stamp[victim]) victim = base + w;
        end
      end
      shadow_valid[victim] = 1'b1;
      shadow_tag[victim] = tag;
      shadow_stamp[victim] = shadow_clock;
    end
    r.hit = found;
    r.fill = !found;
    r.reads = n_reads;
    r.writes = n_writes;
    r.hits = n_hits;
    r.misses = n_misses;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Compare returned results with expectations and track accepted items
  always @(posedge clk) begin : scoreboard
    access_result_t got;
    access_result_t want;
    access_result_t fresh;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.hit = out_tdata[0];
        got.fill = out_tdata[1];
        got.reads = out_tdata[33:2];
        got.writes = out_tdata[65:34];
        got.hits = out_tdata[97:66];
        got.misses = out_tdata[129:98];
        if (pending_results.size() == 0) begin
          report_mismatch("result with no access pending", out_tdata[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.fill !== want.fill) report_mismatch("fill_read", got.fill, want.fill);
          if (got.reads !== want.reads) report_mismatch("total_reads", got.reads, want.reads);
          if (got.writes !== want.writes)
            report_mismatch("total_writes", got.writes, want.writes);
          if (got.hits !== want.hits) report_mismatch("total_hits", got.hits, want.hits);
          if (got.misses !== want.misses)
            report_mismatch("total_misses", got.misses, want.misses);
          if (out_tdata[OUT_DATA_W-1:130] !== '0)
            report_mismatch("padding", out_tdata[OUT_DATA_W-1:130], '0);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LRU_POLICY:  model_lru = cfg_data[0];
          CFG_OFFSET_BITS: model_offset = cfg_data;
          CFG_INDEX_BITS:  model_index_bits = cfg_data[2:0];
          CFG_WAYS_USED:   model_ways = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        fresh = predict_lookup(in_tdata, in_tuser);
        pending_results.push_back(known_valid ? known_res : fresh);
      end
    end
  end

  // Receiver: random stalls per phase, long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      case (flow_mode)
        FLOW_SINK_STALLS: out_tready = ($urandom_range(0, 99) >= 62);
        FLOW_BOTH:        out_tready = ($urandom_range(0, 99) >= 12);
        default:          out_tready = 1'b1;
      endcase
    end
  end

  function automatic int source_gap();
    int pct;
    int n;
    pct = (flow_mode == FLOW_SRC_GAPS) ? 62 : ((flow_mode == FLOW_BOTH) ? 12 : 0);
    n = 0;
    while (n < 40 && $urandom_range(0, 99) < pct) n++;
    return n;
  endfunction

  // Offer one access; valid stays high after acceptance
  task automatic offer_access(input logic [ADDR_W-1:0] a, input logic m, input bit known,
                              input access_result_t res);
    int gap;
    gap = source_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = a;
    in_tuser = m;
    known_valid = known;
    known_res = res;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    known_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly reuse a few tags and sets so hits and evictions happen
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [63:0] raw;
    logic [63:0] tg;
    logic [63:0] st;
    logic [63:0] bt;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 15) return raw[ADDR_W-1:0];
    tg = tag_pool[$urandom_range(0, tag_pool_n - 1)];
    st = set_pool[$urandom_range(0, 3)];
    bt = raw & ((64'd1 << cur_off) - 64'd1);
    raw = (tg << (cur_off + cur_idx)) | (st << cur_off) | bt;
    return raw[ADDR_W-1:0];
  endfunction

  function automatic stim_row_t access_row(logic [ADDR_W-1:0] a, logic m);
    stim_row_t r;
    r = '{kind: ROW_ACCESS, default: '0};
    r.kind = ROW_ACCESS;
    r.addr = a;
    r.mode = m;
    r.known = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t access_row_known(logic [ADDR_W-1:0] a, logic m, logic h,
                                                 logic f, int unsigned rd, int unsigned wr,
                                                 int unsigned hi, int unsigned mi);
    stim_row_t r;
    r = access_row(a, m);
    r.known = 1'b1;
    r.res.hit = h;
    r.res.fill = f;
    r.res.reads = rd;
    r.res.writes = wr;
    r.res.hits = hi;
    r.res.misses = mi;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    stim_row_t r;
    r = '{kind: ROW_REG_WRITE, default: '0};
    r.kind = ROW_REG_WRITE;
    r.reg_idx = i;
    r.reg_val = v;
    return r;
  endfunction

  // Main sequence: reset, directed rows, then random phases
  initial begin
    access_result_t none;
    int             ways_eff;
    none = '{default: '0};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_READ;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LRU_POLICY;
    cfg_data = '0;

    stim_table = '{
      // cold misses, then hits with a different byte offset in the same block
      access_row_known(48'h0, MODE_READ, 1'b0, 1'b1, 1, 0, 0, 1),
      access_row_known(48'hFFFF_FFFF_FFFF, MODE_WRITE, 1'b0, 1'b1, 2, 1, 0, 2),
      access_row_known(48'h0000_0000_000F, MODE_READ, 1'b1, 1'b0, 2, 1, 1, 2),
      access_row_known(48'hFFFF_FFFF_FFF0, MODE_WRITE, 1'b1, 1'b0, 2, 2, 2, 2),
      // two ways, FIFO: a hit does not protect the line
      reg_row(CFG_WAYS_USED, 5'd2),
      access_row(48'h400, MODE_READ),
      access_row(48'h0, MODE_READ),
      access_row(48'h800, MODE_WRITE),
      access_row(48'h0, MODE_READ),
      // LRU: a hit refreshes, the other way goes
      reg_row(CFG_LRU_POLICY, 5'd1),
      access_row(48'h800, MODE_READ),
      access_row(48'hC00, MODE_READ),
      // zero ways acts as one
      reg_row(CFG_WAYS_USED, 5'd0),
      access_row(48'h10, MODE_WRITE),
      access_row(48'h1410, MODE_READ),
      // too many ways saturates; wide index wraps the set
      reg_row(CFG_WAYS_USED, 5'd15),
      reg_row(CFG_OFFSET_BITS, 5'd16),
      reg_row(CFG_INDEX_BITS, 5'h1F),
      access_row(48'h0000_0040_0000, MODE_WRITE),
      reg_row(CFG_OFFSET_BITS, 5'd31),
      access_row(48'hFFFF_FFFF_FFFF, MODE_READ),
      // single set
      reg_row(CFG_INDEX_BITS, 5'd0),
      access_row(48'h1234_5678_9ABC, MODE_WRITE),
      access_row(48'h8000_0000_0000, MODE_READ),
      reg_row(CFG_LRU_POLICY, 5'd0)
    };

    phases = '{
      '{1'b0, 5'd4,  5'd6, 5'd8,  FLOW_FULL},
      '{1'b1, 5'd4,  5'd2, 5'd4,  FLOW_SRC_GAPS},
      '{1'b1, 5'd0,  5'd0, 5'd8,  FLOW_SINK_STALLS},
      '{1'b0, 5'd16, 5'd6, 5'd1,  FLOW_BOTH},
      '{1'b1, 5'd31, 5'd7, 5'd15, FLOW_FULL},
      '{1'b0, 5'd2,  5'd3, 5'd3,  FLOW_SRC_GAPS},
      '{1'b1, 5'd8,  5'd5, 5'd0,  FLOW_SINK_STALLS},
      '{1'b1, 5'd5,  5'd1, 5'd8,  FLOW_BOTH}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // walk the directed rows
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_ACCESS) begin
        offer_access(stim_table[i].addr, stim_table[i].mode, stim_table[i].known,
                     stim_table[i].res);
      end else begin
        drain_results();
        write_register(stim_table[i].reg_idx, stim_table[i].reg_val);
      end
    end

    // random phases, one setting each
    foreach (phases[p]) begin
      drain_results();
      write_register(CFG_LRU_POLICY, {4'b0, phases[p].lru});
      write_register(CFG_OFFSET_BITS, phases[p].off);
      write_register(CFG_INDEX_BITS, phases[p].idx);
      write_register(CFG_WAYS_USED, phases[p].ways);
      cur_off = phases[p].off;
      cur_idx = (phases[p].idx > 7) ? 7 : phases[p].idx;
      ways_eff = (phases[p].ways == 0) ? 1 :
                 ((phases[p].ways > NUM_WAYS) ? NUM_WAYS : phases[p].ways);
      tag_pool_n = ways_eff + 3;
      foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
      tag_pool[0] = '0;
      foreach (set_pool[i]) set_pool[i] = $urandom_range(0, (1 << cur_idx) - 1);
      @(posedge clk);
      flow_mode = phases[p].flow;
      // hold the receiver off so the block fills and stalls its input
      if (p == 2) hold_req = LONG_HOLD;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == PHASE_ITEMS / 2) drain_results();
        offer_access(pick_address(), $urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
                     1'b0, none);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung block
  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: set_assoc_cache_hit_miss_model.f
+incdir+rtl/core
rtl/core/sachm_pkg.sv
rtl/core/sachm_ctrl.sv
rtl/core/sachm_dp.sv
rtl/core/set_assoc_cache_hit_miss_model.sv
tb/tb_set_assoc_cache_hit_miss_model.sv
